/* rtl/pcx_rle_pkg.sv */
// Shared types and constants of the PCX run-length line encoder.
`default_nettype none
package pcx_rle_pkg;

   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned LEN_WIDTH   = 6;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [BYTE_WIDTH-1:0] RUN_MARK   = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] ESCAPE     = 8'hC1;
   localparam logic [1:0]            MARK_BITS  = 2'b11;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] value;
      logic [LEN_WIDTH-1:0]  length;
   } flush_type;

   typedef struct packed {
      logic      first_valid;
      flush_type first;
      logic      eol;
      flush_type second;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/pcx_rle_front.sv */
// Front end: takes input bytes, tracks the pending run and queues run flushes.
`default_nettype none
module pcx_rle_front #(
   parameter int MAX_RUN = 63
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              invert_bytes,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [pcx_rle_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  wire                              req_end_of_line,
   input  wire                              queue_full,
   output logic                             push,
   output pcx_rle_pkg::entry_type           push_entry
);
   import pcx_rle_pkg::*;

   logic [BYTE_WIDTH-1:0] run_value_ff, run_value_in;
   logic [LEN_WIDTH-1:0]  run_length_ff, run_length_in;
   logic [BYTE_WIDTH-1:0] byte_in;
   logic [BYTE_WIDTH-1:0] new_value;
   logic [LEN_WIDTH-1:0]  new_length;
   logic                  extend;
   logic                  accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      byte_in = invert_bytes ? ~req_data_byte : req_data_byte;
      extend  = (run_length_ff != '0) && (byte_in == run_value_ff)
                && (run_length_ff < LEN_WIDTH'(MAX_RUN));
      if (extend) begin
         new_value  = run_value_ff;
         new_length = run_length_ff + LEN_WIDTH'(1);
      end else begin
         new_value  = byte_in;
         new_length = LEN_WIDTH'(1);
      end

      push_entry.first_valid  = !extend && (run_length_ff != '0);
      push_entry.first.value  = run_value_ff;
      push_entry.first.length = run_length_ff;
      push_entry.eol          = req_end_of_line;
      push_entry.second.value = new_value;
      push_entry.second.length = new_length;
      push = accept && (push_entry.first_valid || req_end_of_line);

      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      if (accept) begin
         if (req_end_of_line) begin
            run_value_in  = '0;
            run_length_in = '0;
         end else begin
            run_value_in  = new_value;
            run_length_in = new_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= '0;
         run_length_ff <= '0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
      end
   end

`ifndef SYNTHESIS
   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_length_ff <= LEN_WIDTH'(MAX_RUN))
      else $error("pending run exceeds maximum");
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_line |=> run_length_ff == '0)
      else $error("run survives line end");
`endif

endmodule
`default_nettype wire

/* rtl/pcx_rle_queue.sv */
// Short queue of flush entries between the front and back ends.
`default_nettype none
module pcx_rle_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  pcx_rle_pkg::entry_type push_entry,
   input  wire                    pop,
   output logic                   full,
   output logic                   not_empty,
   output pcx_rle_pkg::entry_type head
);
   import pcx_rle_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
`endif

endmodule
`default_nettype wire

/* rtl/pcx_rle_back.sv */
// Back end: expands queued flushes into code bytes behind an output register.
`default_nettype none
module pcx_rle_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               not_empty,
   input  pcx_rle_pkg::entry_type            head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [pcx_rle_pkg::BYTE_WIDTH-1:0] rsp_code_byte,
   output logic                              rsp_last_of_item,
   output logic                              rsp_line_done
);
   import pcx_rle_pkg::*;

   logic                  sel_ff, sel_in;
   logic                  sub_ff, sub_in;
   logic                  valid_ff, valid_in;
   logic [BYTE_WIDTH-1:0] code_ff, code_in;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;
   logic                  eff_sel;
   flush_type             cur;
   logic                  two_bytes;
   logic                  final_flush;
   logic                  final_entry;
   logic                  load;

   always_comb begin
      eff_sel     = sel_ff || !head.first_valid;
      cur         = eff_sel ? head.second : head.first;
      two_bytes   = (cur.length > LEN_WIDTH'(1))
                    || (cur.value[BYTE_WIDTH-1 -: 2] == MARK_BITS);
      final_flush = sub_ff || !two_bytes;
      final_entry = final_flush && (eff_sel || !head.eol);
      load        = not_empty && (!valid_ff || rsp_ready);
      pop         = load && final_entry;

      if (sub_ff || !two_bytes) begin
         code_in = cur.value;
      end else if (cur.length > LEN_WIDTH'(1)) begin
         code_in = RUN_MARK | BYTE_WIDTH'(cur.length);
      end else begin
         code_in = ESCAPE;
      end
      last_in = final_entry;
      done_in = final_entry && head.eol;

      valid_in = valid_ff && !rsp_ready;
      sel_in   = sel_ff;
      sub_in   = sub_ff;
      if (load) begin
         valid_in = 1'b1;
         if (final_entry) begin
            sel_in = 1'b0;
            sub_in = 1'b0;
         end else if (final_flush) begin
            sel_in = 1'b1;
            sub_in = 1'b0;
         end else begin
            sel_in = eff_sel;
            sub_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code_byte    = code_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_line_done    = done_ff;

`ifndef SYNTHESIS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && done_ff |-> last_ff)
      else $error("line end on a byte that is not the last of its transfer");
   a_mid_entry_held: assert property (@(posedge clock) disable iff (reset)
      (sel_ff || sub_ff) |-> not_empty)
      else $error("expansion in progress with empty queue");
`endif

endmodule
`default_nettype wire

/* rtl/pcx_rle_line_encoder.sv */
// Top level of the PCX run-length line encoder.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   data_byte, end_of_line
//   rsp      out        rsp_valid / rsp_ready   code_byte, last_of_item, line_done
//   csr      in         csr_write_enable        invert_bytes (write only)
//
// One input transfer is taken per cycle while the flush queue has room.
// Each input gives zero to four code bytes; the back end emits one per cycle
// while the queue holds entries and rsp_ready is high.
// Code bytes pass from the input through the queue and then the output register.
// Synchronous reset clears the pending run, the queue and the output register.
// A stalled rsp holds the output register; the front keeps accepting until the queue fills.
`default_nettype none
module pcx_rle_line_encoder #(
   parameter int MAX_RUN = 63
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_write_enable,
   input  wire                                csr_write_data,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [pcx_rle_pkg::BYTE_WIDTH-1:0]  req_data_byte,
   input  wire                                req_end_of_line,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [pcx_rle_pkg::BYTE_WIDTH-1:0] rsp_code_byte,
   output logic                               rsp_last_of_item,
   output logic                               rsp_line_done
);
   import pcx_rle_pkg::*;

   logic      invert_ff, invert_in;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      queue_full;
   logic      queue_not_empty;
   entry_type head;

   assign invert_in = csr_write_enable ? csr_write_data : invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b1;
      end else begin
         invert_ff <= invert_in;
      end
   end

   pcx_rle_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .invert_bytes    (invert_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_line (req_end_of_line),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   pcx_rle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   pcx_rle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (queue_not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_line_done    (rsp_line_done)
   );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the PCX run-length line encoder, random traffic on both channels.
`timescale 1ns / 100ps
module testbench;
   import pcx_rle_pkg::*;

   localparam int RUN_LIMIT = 63;

   typedef struct {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  end_of_line;
   } line_byte_type;

   typedef struct {
      logic [BYTE_WIDTH-1:0] code_byte;
      logic                  last_of_item;
      logic                  line_done;
   } code_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data = 1'b0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_WIDTH-1:0] req_data_byte = '0;
   logic                  req_end_of_line = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_WIDTH-1:0] rsp_code_byte;
   logic                  rsp_last_of_item;
   logic                  rsp_line_done;

   line_byte_type pending_bytes[$];
   code_type      expected_codes[$];

   logic                  invert_on = 1'b1;
   logic [BYTE_WIDTH-1:0] line_run_value = '0;
   logic [LEN_WIDTH-1:0]  line_run_length = '0;

   int unsigned mismatch_count = 0;
   int unsigned req_hold = 0;
   int unsigned rsp_hold = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   pcx_rle_line_encoder #(.MAX_RUN(RUN_LIMIT)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_line  (req_end_of_line),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_line_done    (rsp_line_done)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic log_mismatch(string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic add_code(logic [BYTE_WIDTH-1:0] code);
      code_type c;
      c.code_byte = code;
      c.last_of_item = 1'b0;
      c.line_done = 1'b0;
      expected_codes.push_back(c);
   endtask

   task automatic flush_run();
      if (line_run_length >= 2) begin
         add_code(RUN_MARK | {2'b00, line_run_length});
         add_code(line_run_value);
      end else if (line_run_length == 1) begin
         if (line_run_value[7:6] == MARK_BITS)
            add_code(ESCAPE);
         add_code(line_run_value);
      end
      line_run_length = '0;
   endtask

   task automatic encode_byte(logic [BYTE_WIDTH-1:0] data, logic eol);
      logic [BYTE_WIDTH-1:0] b;
      int unsigned           before_n;
      code_type              tail;
      before_n = expected_codes.size();
      b = invert_on ? ~data : data;
      if (line_run_length != 0 && b == line_run_value && line_run_length < RUN_LIMIT) begin
         line_run_length = line_run_length + 1'b1;
      end else begin
         flush_run();
         line_run_value = b;
         line_run_length = LEN_WIDTH'(1);
      end
      if (eol) begin
         flush_run();
         line_run_value = '0;
      end
      if (expected_codes.size() > before_n) begin
         tail = expected_codes.pop_back();
         tail.last_of_item = 1'b1;
         tail.line_done = eol;
         expected_codes.push_back(tail);
      end
   endtask

   // input side: one transfer per item, random gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold <= 0;
      end else begin : req_side
         line_byte_type item;
         if (req_valid && req_ready)
            encode_byte(req_data_byte, req_end_of_line);
         if (!req_valid || req_ready) begin
            if (req_hold != 0) begin
               req_hold <= req_hold - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= item.data_byte;
               req_end_of_line <= item.end_of_line;
               if ($urandom_range(0, 29) == 0)
                  req_burst <= !req_burst;
               req_hold <= req_burst ? 0 : $urandom_range(0, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: check each transfer, random stall after each
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else begin : rsp_side
         code_type    want;
         int unsigned wait_n;
         wait_n = rsp_hold;
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               log_mismatch($sformatf("unexpected code byte %02h", rsp_code_byte));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_code_byte !== want.code_byte)
                  log_mismatch($sformatf("code_byte %02h, want %02h",
                                         rsp_code_byte, want.code_byte));
               if (rsp_last_of_item !== want.last_of_item)
                  log_mismatch($sformatf("last_of_item %b, want %b",
                                         rsp_last_of_item, want.last_of_item));
               if (rsp_line_done !== want.line_done)
                  log_mismatch($sformatf("line_done %b, want %b",
                                         rsp_line_done, want.line_done));
            end
            if ($urandom_range(0, 29) == 0)
               rsp_burst <= !rsp_burst;
            wait_n = rsp_burst ? 0 : $urandom_range(0, 11);
         end
         if (wait_n != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= wait_n - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold <= 0;
         end
      end
   end

   task automatic queue_byte(logic [BYTE_WIDTH-1:0] data, logic eol);
      line_byte_type item;
      item.data_byte = data;
      item.end_of_line = eol;
      pending_bytes.push_back(item);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_codes.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_invert(logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      invert_on = value;
      @(negedge clock);
   endtask

   // well-formed lines built from runs, with some stray bytes mixed in
   task automatic queue_random_lines(int unsigned budget, bit open_long);
      int unsigned           made;
      int unsigned           runs;
      int unsigned           run_n;
      logic [BYTE_WIDTH-1:0] value;
      made = 0;
      while (made < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_byte(BYTE_WIDTH'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            made++;
         end else begin
            runs = $urandom_range(1, 6);
            for (int r = 0; r < runs; r++) begin
               case ($urandom_range(0, 9))
                  0:       run_n = $urandom_range(55, 70);
                  1, 2:    run_n = $urandom_range(4, 20);
                  default: run_n = $urandom_range(1, 3);
               endcase
               if (open_long) begin
                  run_n = $urandom_range(63, 66);
                  open_long = 1'b0;
               end
               value = BYTE_WIDTH'($urandom_range(0, 255));
               case ($urandom_range(0, 3))
                  0:       value[7:6] = MARK_BITS;
                  1:       value[7:6] = ~MARK_BITS;
                  default: ;
               endcase
               for (int i = 0; i < run_n; i++) begin
                  queue_byte(value, (r == runs - 1) && (i == run_n - 1));
                  made++;
               end
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_byte(8'h00, 1'b1);
      queue_byte(8'h3F, 1'b0);
      queue_byte(8'h3F, 1'b1);
      queue_byte(8'hFF, 1'b1);
      wait_until_drained();

      write_invert(1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hC0, 1'b0);
      queue_byte(8'hC0, 1'b1);
      queue_byte(8'h3F, 1'b0);
      queue_byte(8'h3F, 1'b0);
      queue_byte(8'h3F, 1'b0);
      queue_byte(8'hBF, 1'b0);
      queue_byte(8'hE0, 1'b0);
      queue_byte(8'hD0, 1'b1);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'h40, 1'b1);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'h7F, 1'b1);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b1);
      wait_until_drained();

      for (int p = 0; p < 6; p++) begin
         if (p < 2)
            write_invert(p == 0);
         else
            write_invert(1'($urandom_range(0, 1)));
         queue_random_lines(20, p < 2);
         wait_until_drained();
      end

      if (mismatch_count == 0)
         $display("pcx_rle_line_encoder verification clean");
      else
         $display("pcx_rle_line_encoder verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("pcx_rle_line_encoder verification failed");
      $finish;
   end

endmodule
